@@ hw/rtl/cap_pkg.sv @@
// ----------------------------------------------------------------------------
// Command APDU parser package
// Shared codes, the result record and the length decode helpers.
// ----------------------------------------------------------------------------
package cap_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_SUM  = 2'd1;
  localparam logic [1:0] KIND_BOTH = 2'd2;

  // ISO command cases.
  localparam logic [2:0] CASE_NONE = 3'd0;
  localparam logic [2:0] CASE_1    = 3'd1;
  localparam logic [2:0] CASE_2    = 3'd2;
  localparam logic [2:0] CASE_3    = 3'd3;
  localparam logic [2:0] CASE_4    = 3'd4;

  // Error codes.
  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_HEADER = 2'd1;
  localparam logic [1:0] ERR_DATA   = 2'd2;
  localparam logic [1:0] ERR_LE     = 2'd3;

  // Length limits of the short and extended encodings.
  localparam logic [16:0] SHORT_MAX    = 17'd256;
  localparam logic [16:0] EXTENDED_MAX = 17'd65536;

  // One result item as it travels from the parser to the output stage.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [7:0]  cla;
    logic [7:0]  ins;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [16:0] nc;
    logic [16:0] ne;
    logic [2:0]  acase;
    logic        ext;
    logic [1:0]  err;
    logic        trail;
  } cap_rec_t;

  // A short length of zero stands for the maximum.
  function automatic logic [16:0] dec_short(input logic [7:0] b);
    logic [16:0] r;
    r = (b == 8'd0) ? SHORT_MAX : {9'd0, b};
    return r;
  endfunction

  // An extended length of zero stands for the maximum.
  function automatic logic [16:0] dec_ext(input logic [7:0] hi, input logic [7:0] lo);
    logic [16:0] r;
    r = ({hi, lo} == 16'd0) ? EXTENDED_MAX : {1'b0, hi, lo};
    return r;
  endfunction

endpackage

@@ hw/rtl/cap_front.sv @@
// ----------------------------------------------------------------------------
// Command APDU parser front end
// Accepts APDU bytes, tracks the parse phase and builds result records.
// ----------------------------------------------------------------------------
module cap_front
  import cap_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       final_byte_i,
  input  logic [7:0] byte_value_i,
  output logic       push_o,
  output cap_rec_t   rec_o
);

  localparam logic [2:0] PH_HEAD  = 3'd0;
  localparam logic [2:0] PH_LEN   = 3'd1;
  localparam logic [2:0] PH_PEND  = 3'd2;
  localparam logic [2:0] PH_EXT   = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_LE    = 3'd5;
  localparam logic [2:0] PH_LE2   = 3'd6;
  localparam logic [2:0] PH_TRAIL = 3'd7;

  logic [2:0]       phase_q, phase_d;
  logic [1:0]       hidx_q;
  logic [3:0][7:0]  hdr_q, hdr_cur;
  logic [16:0]      nc_q, nc_d;
  logic [16:0]      seen_q, seen_d, seen_inc;
  logic [16:0]      ne_q, ne_d;
  logic [7:0]       lb1_q, lb1_d;
  logic [7:0]       le_first_q, le_first_d;
  logic             ext_q, ext_d;
  logic             emit;

  assign seen_inc = seen_q + 17'd1;

  // Phase decode: next state and the result record for the current byte.
  always_comb begin
    hdr_cur = hdr_q;
    if (phase_q == PH_HEAD) begin
      hdr_cur[hidx_q] = byte_value_i;
    end
    phase_d    = phase_q;
    nc_d       = nc_q;
    seen_d     = seen_q;
    ne_d       = ne_q;
    lb1_d      = lb1_q;
    le_first_d = le_first_q;
    ext_d      = ext_q;
    emit       = final_byte_i;

    rec_o.kind  = KIND_SUM;
    rec_o.data  = byte_value_i;
    rec_o.cla   = hdr_cur[0];
    rec_o.ins   = hdr_cur[1];
    rec_o.p1    = hdr_cur[2];
    rec_o.p2    = hdr_cur[3];
    rec_o.nc    = nc_q;
    rec_o.ne    = ne_q;
    rec_o.acase = CASE_1;
    rec_o.ext   = ext_q;
    rec_o.err   = ERR_OK;
    rec_o.trail = 1'b0;

    case (phase_q)
      PH_HEAD: begin
        if (hidx_q == 2'd3) begin
          phase_d = PH_LEN;
        end else begin
          rec_o.err = ERR_HEADER;
        end
      end
      PH_LEN: begin
        rec_o.ne    = dec_short(byte_value_i);
        rec_o.acase = CASE_2;
        if (byte_value_i == 8'd0) begin
          phase_d = PH_PEND;
        end else begin
          nc_d    = {9'd0, byte_value_i};
          phase_d = PH_DATA;
        end
      end
      PH_PEND: begin
        // A zero fifth byte followed by only one more byte is short form.
        lb1_d       = byte_value_i;
        rec_o.kind  = KIND_BOTH;
        rec_o.nc    = SHORT_MAX;
        rec_o.acase = CASE_3;
        rec_o.err   = ERR_DATA;
        phase_d     = PH_EXT;
      end
      PH_EXT: begin
        ext_d       = 1'b1;
        rec_o.ext   = 1'b1;
        rec_o.ne    = dec_ext(lb1_q, byte_value_i);
        rec_o.acase = CASE_2;
        nc_d        = dec_ext(lb1_q, byte_value_i);
        phase_d     = PH_DATA;
      end
      PH_DATA: begin
        emit        = 1'b1;
        seen_d      = seen_inc;
        rec_o.kind  = final_byte_i ? KIND_BOTH : KIND_DATA;
        rec_o.acase = CASE_3;
        rec_o.err   = (seen_inc < nc_q) ? ERR_DATA : ERR_OK;
        if (seen_inc >= nc_q) begin
          phase_d = PH_LE;
        end
      end
      PH_LE: begin
        rec_o.acase = CASE_4;
        if (!ext_q) begin
          ne_d     = dec_short(byte_value_i);
          rec_o.ne = dec_short(byte_value_i);
          phase_d  = PH_TRAIL;
        end else begin
          le_first_d = byte_value_i;
          rec_o.err  = ERR_LE;
          phase_d    = PH_LE2;
        end
      end
      PH_LE2: begin
        ne_d        = dec_ext(le_first_q, byte_value_i);
        rec_o.ne    = dec_ext(le_first_q, byte_value_i);
        rec_o.acase = CASE_4;
        phase_d     = PH_TRAIL;
      end
      default: begin
        rec_o.acase = CASE_4;
        rec_o.trail = 1'b1;
      end
    endcase
  end

  assign push_o = accept_i && emit;

  // Parse state; a final byte returns everything to the start of an APDU.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEAD;
      hidx_q     <= 2'd0;
      hdr_q      <= '0;
      nc_q       <= '0;
      seen_q     <= '0;
      ne_q       <= '0;
      lb1_q      <= '0;
      le_first_q <= '0;
      ext_q      <= 1'b0;
    end else if (accept_i) begin
      if (final_byte_i) begin
        phase_q    <= PH_HEAD;
        hidx_q     <= 2'd0;
        hdr_q      <= '0;
        nc_q       <= '0;
        seen_q     <= '0;
        ne_q       <= '0;
        lb1_q      <= '0;
        le_first_q <= '0;
        ext_q      <= 1'b0;
      end else begin
        phase_q    <= phase_d;
        hdr_q      <= hdr_cur;
        nc_q       <= nc_d;
        seen_q     <= seen_d;
        ne_q       <= ne_d;
        lb1_q      <= lb1_d;
        le_first_q <= le_first_d;
        ext_q      <= ext_d;
        if (phase_q == PH_HEAD) begin
          hidx_q <= hidx_q + 2'd1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  // Every final byte produces a summary.
  a_final_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && final_byte_i |-> push_o && rec_o.kind != KIND_DATA)
    else $error("final byte without summary");

  // A data-only item comes from the data phase alone.
  a_data_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && rec_o.kind == KIND_DATA |-> phase_q == PH_DATA && !final_byte_i)
    else $error("data item outside data phase");

  // After a final byte the parser is back at the header.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && final_byte_i |=> phase_q == PH_HEAD && hidx_q == 2'd0)
    else $error("parser did not restart");

  // Nothing is pushed without an accepted byte.
  a_push_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> accept_i)
    else $error("push without accepted item");
`endif

endmodule

@@ hw/rtl/cap_queue.sv @@
// ----------------------------------------------------------------------------
// Command APDU parser result queue
// Small FIFO of result records between the parser and the output stage.
// ----------------------------------------------------------------------------
module cap_queue
  import cap_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  cap_rec_t rec_i,
  input  logic     pop_i,
  output cap_rec_t rec_o,
  output logic     empty_o,
  output logic     full_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  cap_rec_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == DepthCnt);
  assign rec_o   = mem_q[rd_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt)
    else $error("queue count out of range");
`endif

endmodule

@@ hw/rtl/cap_back.sv @@
// ----------------------------------------------------------------------------
// Command APDU parser output stage
// Takes records from the queue and presents them as result items.
// ----------------------------------------------------------------------------
module cap_back
  import cap_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cap_rec_t    rec_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_data_byte_o,
  output logic [7:0]  out_class_byte_o,
  output logic [7:0]  out_instruction_o,
  output logic [7:0]  out_param_one_o,
  output logic [7:0]  out_param_two_o,
  output logic [16:0] out_data_length_o,
  output logic [16:0] out_expected_length_o,
  output logic [2:0]  out_apdu_case_o,
  output logic        out_extended_form_o,
  output logic [1:0]  out_error_code_o,
  output logic        out_trailing_ignored_o
);

  logic     valid_q;
  cap_rec_t out_q, fmt;
  logic     is_sum;

  // Load when the output register is empty or being taken.
  assign pop_o = !empty_i && (!valid_q || !out_stall_i);

  // Summary fields are zero on data-only items, the data byte on summary-only.
  always_comb begin
    is_sum = (rec_i.kind != KIND_DATA);
    fmt = '0;
    fmt.kind = rec_i.kind;
    fmt.data = (rec_i.kind == KIND_SUM) ? 8'd0 : rec_i.data;
    if (is_sum) begin
      fmt.cla   = rec_i.cla;
      fmt.ins   = rec_i.ins;
      fmt.p1    = rec_i.p1;
      fmt.p2    = rec_i.p2;
      fmt.nc    = rec_i.nc;
      fmt.ne    = rec_i.ne;
      fmt.acase = rec_i.acase;
      fmt.ext   = rec_i.ext;
      fmt.err   = rec_i.err;
      fmt.trail = rec_i.trail;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= fmt;
    end
  end

  assign out_valid_o            = valid_q;
  assign out_kind_o             = out_q.kind;
  assign out_data_byte_o        = out_q.data;
  assign out_class_byte_o       = out_q.cla;
  assign out_instruction_o      = out_q.ins;
  assign out_param_one_o        = out_q.p1;
  assign out_param_two_o        = out_q.p2;
  assign out_data_length_o      = out_q.nc;
  assign out_expected_length_o  = out_q.ne;
  assign out_apdu_case_o        = out_q.acase;
  assign out_extended_form_o    = out_q.ext;
  assign out_error_code_o       = out_q.err;
  assign out_trailing_ignored_o = out_q.trail;

`ifndef SYNTHESIS
  // A data-only item carries no summary.
  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_DATA |->
      out_apdu_case_o == CASE_NONE && out_error_code_o == ERR_OK)
    else $error("data item with summary fields");

  // A summary always names a case.
  a_sum_case: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o != KIND_DATA |-> out_apdu_case_o != CASE_NONE)
    else $error("summary without case");

  // A held item is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !valid_q || !out_stall_i)
    else $error("output register overwritten");
`endif

endmodule

@@ hw/rtl/command_apdu_parser.sv @@
// ----------------------------------------------------------------------------
// Command APDU parser
// Parses a command APDU byte by byte, forwards command data and reports
// header, Nc, Ne, case and errors on the final byte.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid_i/in_stall_o  byte_value, final_byte
//  out      output     out_valid_o/out_stall_i kind, data_byte, summary fields
//
// Each byte is parsed in the cycle it is accepted; one byte per cycle while the input is not stalled.
// A result is written into the result queue as its byte is accepted and is then
// moved from the queue into the output register, where out_stall_i holds it.
// The input stalls only while the result queue (QueueDepth entries) is full.
// Reset puts the parser at the start of an APDU with all fields cleared.
// ----------------------------------------------------------------------------
module command_apdu_parser
  import cap_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_value_i,
  input  logic        in_final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_data_byte_o,
  output logic [7:0]  out_class_byte_o,
  output logic [7:0]  out_instruction_o,
  output logic [7:0]  out_param_one_o,
  output logic [7:0]  out_param_two_o,
  output logic [16:0] out_data_length_o,
  output logic [16:0] out_expected_length_o,
  output logic [2:0]  out_apdu_case_o,
  output logic        out_extended_form_o,
  output logic [1:0]  out_error_code_o,
  output logic        out_trailing_ignored_o
);

  logic     accept, push, pop, full, empty;
  cap_rec_t push_rec, head_rec;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  cap_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .final_byte_i (in_final_byte_i),
    .byte_value_i (in_byte_value_i),
    .push_o       (push),
    .rec_o        (push_rec)
  );

  cap_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .pop_i   (pop),
    .rec_o   (head_rec),
    .empty_o (empty),
    .full_o  (full)
  );

  cap_back u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .rec_i                  (head_rec),
    .empty_i                (empty),
    .pop_o                  (pop),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .out_kind_o             (out_kind_o),
    .out_data_byte_o        (out_data_byte_o),
    .out_class_byte_o       (out_class_byte_o),
    .out_instruction_o      (out_instruction_o),
    .out_param_one_o        (out_param_one_o),
    .out_param_two_o        (out_param_two_o),
    .out_data_length_o      (out_data_length_o),
    .out_expected_length_o  (out_expected_length_o),
    .out_apdu_case_o        (out_apdu_case_o),
    .out_extended_form_o    (out_extended_form_o),
    .out_error_code_o       (out_error_code_o),
    .out_trailing_ignored_o (out_trailing_ignored_o)
  );

endmodule
